// ===== rtl/fccl_pkg.sv =====
// ============================================================================
// fccl_pkg - shared constants for the fat cluster chain lookup
// FAT kind codes, kind limits, end-of-chain values, request codes, configuration register indexes and beat widths.
// ============================================================================
package fccl_pkg;

    localparam int TABLE_BYTES_DEFAULT = 16384;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START_SECTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SECTORS   = 2'd2;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [1:0] KIND_FAT12 = 2'd0;
    localparam logic [1:0] KIND_FAT16 = 2'd1;
    localparam logic [1:0] KIND_FAT32 = 2'd2;

    localparam logic [27:0] FAT12_LIMIT = 28'd4085;
    localparam logic [27:0] FAT16_LIMIT = 28'd65525;
    localparam logic [27:0] MASK12      = 28'h0000FFF;
    localparam logic [27:0] EOC_FAT12   = 28'h0000FF8;
    localparam logic [27:0] EOC_FAT16   = 28'h000FFF8;
    localparam logic [27:0] EOC_FAT32   = 28'hFFFFFF8;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;

endpackage

// ===== rtl/fccl_ram.sv =====
// ============================================================================
// fccl_ram - generic simple dual port ram
// One write port, one read port with registered read data.
// ============================================================================
module fccl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fccl_table.sv =====
// ============================================================================
// fccl_table - byte table in four interleaved banks
// Byte writes, and reads of four consecutive bytes at any byte position,
// returned little-endian in the cycle after the read request.
// ============================================================================
module fccl_table #(
    parameter int TABLE_BYTES = 16384
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(TABLE_BYTES)-1:0] i_waddr,
    input  logic [7:0]                     i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(TABLE_BYTES)-1:0] i_rpos,
    output logic [31:0]                    o_word
);

    localparam int AW    = $clog2(TABLE_BYTES);
    localparam int DEPTH = (TABLE_BYTES + 3) / 4;
    localparam int RW    = $clog2(DEPTH);

    logic [7:0]    w_bank_q [4];
    logic [RW-1:0] w_raddr  [4];
    logic [1:0]    r_ofs;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        assign w_raddr[b] = RW'(i_rpos[AW-1:2]) +
                            RW'((2'(b) < i_rpos[1:0]) ? 1 : 0);

        fccl_ram #(
            .WIDTH (8),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_we && (i_waddr[1:0] == 2'(b))),
            .i_waddr (RW'(i_waddr[AW-1:2])),
            .i_wdata (i_wdata),
            .i_re    (i_re),
            .i_raddr (w_raddr[b]),
            .o_rdata (w_bank_q[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_ofs <= i_rpos[1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_word[8*k +: 8] = w_bank_q[r_ofs + 2'(k)];
        end
    end

endmodule

// ===== rtl/fat_cluster_chain_lookup.sv =====
// ============================================================================
// fat_cluster_chain_lookup - next-cluster lookup on a loaded FAT copy
// Byte loads into an on-chip table, lookups give entry, sector and flags.
// ============================================================================
// One beat is taken every cycle, load or lookup alike, unless both pipeline
// stages are full and the master side stalls. A lookup result reaches the
// master side through the registered read of the four table banks (which
// also holds the sector product) and then the result register. Loads give no
// result and are written into the table at the cycle they are taken, so a
// lookup in the next beat already sees them. Table memory comes up undefined
// and is not cleared. Configuration is written through the plain write port;
// the user must write it only while no lookup is in flight, the block does not enforce this.
module fat_cluster_chain_lookup #(
    parameter int TABLE_BYTES = fccl_pkg::TABLE_BYTES_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fccl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fccl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // byte_index[13:0], byte_value[21:14], cluster[49:22], zero pad
    input  logic [fccl_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // req_type[0]
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // next_entry[27:0], first_sector[59:28], chain_end[60], outside_table[61]
    output logic [fccl_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // fat_kind[1:0]
    output logic [1:0]                         o_m_tuser
);

    import fccl_pkg::*;

    localparam int AW = $clog2(TABLE_BYTES);
    localparam logic [31:0] TBL_END = 32'(TABLE_BYTES);

    logic [27:0] r_cluster_count;
    logic [31:0] r_data_start;
    logic [7:0]  r_cluster_sectors;

    logic        r_s1_valid;
    logic        r_s1_odd;
    logic [1:0]  r_s1_kind;
    logic        r_s1_outside;
    logic        r_s1_ge2;
    logic [31:0] r_s1_prod;

    logic        r_o_valid;
    logic [27:0] r_o_entry;
    logic [31:0] r_o_sector;
    logic        r_o_end;
    logic        r_o_outside;
    logic [1:0]  r_o_kind;

    logic [13:0] w_bidx;
    logic [7:0]  w_bval;
    logic [27:0] w_cl;
    logic        w_accept;
    logic        w_load;
    logic        w_lookup;
    logic        w_s1_go;
    logic [1:0]  w_kind;
    logic [31:0] w_pos;
    logic [31:0] w_len;
    logic        w_outside;
    logic [35:0] w_prod;
    logic [31:0] w_word;
    logic [15:0] w_w16;
    logic [27:0] n_entry;
    logic [27:0] w_eoc;
    logic        n_end;
    logic [31:0] n_sector;

    assign w_bidx = i_s_tdata[13:0];
    assign w_bval = i_s_tdata[21:14];
    assign w_cl   = i_s_tdata[49:22];

    assign w_s1_go    = !r_o_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || w_s1_go;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = w_accept && (i_s_tuser == REQ_LOAD) && (32'(w_bidx) < TBL_END);
    assign w_lookup   = w_accept && (i_s_tuser == REQ_LOOKUP);

    always_comb begin
        if (r_cluster_count < FAT12_LIMIT) begin
            w_kind = KIND_FAT12;
        end else if (r_cluster_count < FAT16_LIMIT) begin
            w_kind = KIND_FAT16;
        end else begin
            w_kind = KIND_FAT32;
        end
        case (w_kind)
            KIND_FAT12: begin
                w_pos = 32'(w_cl) + 32'(w_cl[27:1]);
                w_len = 32'd2;
            end
            KIND_FAT16: begin
                w_pos = {3'b0, w_cl, 1'b0};
                w_len = 32'd2;
            end
            default: begin
                w_pos = {2'b0, w_cl, 2'b0};
                w_len = 32'd4;
            end
        endcase
        w_outside = (w_pos + w_len) > TBL_END;
    end

    assign w_prod = 36'(w_cl - 28'd2) * 36'(r_cluster_sectors);

    fccl_table #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (AW'(w_bidx)),
        .i_wdata (w_bval),
        .i_re    (w_lookup),
        .i_rpos  (w_pos[AW-1:0]),
        .o_word  (w_word)
    );

    always_comb begin
        w_w16 = w_word[15:0];
        case (r_s1_kind)
            KIND_FAT12: begin
                n_entry = r_s1_odd ? 28'(w_w16[15:4]) : (28'(w_w16) & MASK12);
                w_eoc   = EOC_FAT12;
            end
            KIND_FAT16: begin
                n_entry = 28'(w_w16);
                w_eoc   = EOC_FAT16;
            end
            default: begin
                n_entry = w_word[27:0];
                w_eoc   = EOC_FAT32;
            end
        endcase
        if (r_s1_outside) begin
            n_entry = 28'd0;
        end
        n_end    = (n_entry == 28'd0) || (n_entry >= w_eoc);
        n_sector = r_s1_ge2 ? (r_data_start + r_s1_prod) : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count   <= 28'd0;
            r_data_start      <= 32'd0;
            r_cluster_sectors <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLUSTER_COUNT:     r_cluster_count   <= i_cfg_data[27:0];
                CFG_DATA_START_SECTOR: r_data_start      <= i_cfg_data;
                CFG_CLUSTER_SECTORS:   r_cluster_sectors <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_s1_valid <= w_lookup;
            end
            if (w_s1_go) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lookup) begin
            r_s1_odd     <= w_cl[0];
            r_s1_kind    <= w_kind;
            r_s1_outside <= w_outside;
            r_s1_ge2     <= (w_cl >= 28'd2);
            r_s1_prod    <= w_prod[31:0];
        end
        if (w_s1_go && r_s1_valid) begin
            r_o_entry   <= n_entry;
            r_o_sector  <= n_sector;
            r_o_end     <= n_end;
            r_o_outside <= r_s1_outside;
            r_o_kind    <= r_s1_kind;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {2'b0, r_o_outside, r_o_end, r_o_sector, r_o_entry};
    assign o_m_tuser  = r_o_kind;

    // a load beat never fills the lookup stage
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_s_tuser == REQ_LOAD) && !r_s1_valid) |=> !r_s1_valid)
        else $error("load beat entered the lookup stage");

    // an outside read gives a zero entry and ends the chain
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_outside) |-> (r_o_entry == 28'd0) && r_o_end)
        else $error("outside read with nonzero entry");

    // backpressure only when both stages are full and the sink stalls
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_valid && r_o_valid && !i_m_tready))
        else $error("input stalled without a full pipeline");

    // a result that is taken with the lookup stage full is replaced next cycle
    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_m_tready && r_s1_valid) |=> r_o_valid)
        else $error("pending lookup lost");

endmodule

// ===== tb/sv/tb_fat_cluster_chain_lookup.sv =====
// ============================================================================
// tb_fat_cluster_chain_lookup - self-checking bench for the FAT chain lookup
// Loads table bytes and looks up clusters under FAT12, FAT16 and FAT32
// configurations. Every result beat is checked against a prediction from a
// local copy of the table, or against a given result for a few directed rows.
// A short directed table comes first, then random phases with bursty input and
// a stalling output side.
module tb_fat_cluster_chain_lookup;
    import fccl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_BYTES = fccl_pkg::TABLE_BYTES_DEFAULT;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int N_PHASES = 8;
    localparam int PHASE_BEATS = 240;

    typedef struct packed {
        logic [27:0] next_entry;
        logic [31:0] first_sector;
        logic        chain_end;
        logic [1:0]  fat_kind;
        logic        outside_table;
    } chain_res_t;

    typedef struct {
        bit                   is_cfg;
        logic                 req;
        logic [13:0]          idx;
        logic [7:0]           val;
        logic [27:0]          cl;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [31:0]          reg_data;
        bit                   typed;
        chain_res_t           res;
    } dir_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // byte_index[13:0], byte_value[21:14], cluster[49:22], zero pad
    logic [S_TDATA_W-1:0]  i_s_tdata = '0;
    // req_type[0]
    logic                  i_s_tuser = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // next_entry[27:0], first_sector[59:28], chain_end[60], outside_table[61]
    logic [M_TDATA_W-1:0]  o_m_tdata;
    // fat_kind[1:0]
    logic [1:0]            o_m_tuser;

    fat_cluster_chain_lookup #(
        .TABLE_BYTES(TBL_BYTES)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // model state
    logic [7:0]  fat_image [TBL_BYTES];
    bit          written [TBL_BYTES];
    logic [27:0] cfg_count = '0;
    logic [31:0] cfg_start = '0;
    logic [7:0]  cfg_secs = 8'd1;
    chain_res_t  pending_q [$];

    logic        note_typed = 1'b0;
    chain_res_t  note_res = '0;

    int n_err = 0;
    int n_loads = 0;
    int n_lookups = 0;
    int n_checked = 0;
    int n_sent = 0;
    int burst_left = 0;
    bit steady_sender = 1'b0;

    function automatic logic [1:0] fat_kind_of(input logic [27:0] count);
        if (count < FAT12_LIMIT) return KIND_FAT12;
        else if (count < FAT16_LIMIT) return KIND_FAT16;
        return KIND_FAT32;
    endfunction

    function automatic void entry_span(input logic [27:0] cl, input logic [1:0] kind,
                                       output longint unsigned pos, output int len);
        case (kind)
            KIND_FAT12: begin
                pos = 64'(cl) + 64'(cl >> 1);
                len = 2;
            end
            KIND_FAT16: begin
                pos = 64'(cl) * 2;
                len = 2;
            end
            default: begin
                pos = 64'(cl) * 4;
                len = 4;
            end
        endcase
    endfunction

    function automatic int max_cluster(input logic [1:0] kind);
        case (kind)
            KIND_FAT12: return (TBL_BYTES - 2) * 2 / 3;
            KIND_FAT16: return TBL_BYTES / 2 - 1;
            default:    return TBL_BYTES / 4 - 1;
        endcase
    endfunction

    function automatic chain_res_t predict_lookup(input logic [27:0] cl);
        chain_res_t r;
        longint unsigned pos;
        int len;
        logic [31:0] w;
        logic [27:0] eoc;
        r = '0;
        w = '0;
        r.fat_kind = fat_kind_of(cfg_count);
        entry_span(cl, r.fat_kind, pos, len);
        r.outside_table = (pos + 64'(len) > 64'(TBL_BYTES));
        if (!r.outside_table) begin
            for (int i = 0; i < len; i++) begin
                w = w | (32'(fat_image[int'(pos) + i]) << (8 * i));
            end
        end
        case (r.fat_kind)
            KIND_FAT12: begin
                r.next_entry = cl[0] ? 28'(w[15:4]) : 28'(w[11:0]);
                eoc = EOC_FAT12;
            end
            KIND_FAT16: begin
                r.next_entry = 28'(w[15:0]);
                eoc = EOC_FAT16;
            end
            default: begin
                r.next_entry = w[27:0];
                eoc = EOC_FAT32;
            end
        endcase
        if (cl >= 28'd2) begin
            r.first_sector = cfg_start + (32'(cl) - 32'd2) * {24'd0, cfg_secs};
        end
        r.chain_end = (r.next_entry == '0) || (r.next_entry >= eoc);
        return r;
    endfunction

    function automatic bit lookup_safe(input logic [27:0] cl, input logic [1:0] kind);
        longint unsigned pos;
        int len;
        entry_span(cl, kind, pos, len);
        if (pos + 64'(len) > 64'(TBL_BYTES)) return 1'b1;
        for (int i = 0; i < len; i++) begin
            if (!written[int'(pos) + i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [27:0] pick_entry(input logic [1:0] kind);
        logic [27:0] m;
        logic [27:0] eoc;
        case (kind)
            KIND_FAT12: begin
                m = 28'h0000FFF;
                eoc = EOC_FAT12;
            end
            KIND_FAT16: begin
                m = 28'h000FFFF;
                eoc = EOC_FAT16;
            end
            default: begin
                m = 28'hFFFFFFF;
                eoc = EOC_FAT32;
            end
        endcase
        case ($urandom % 6)
            0: return '0;
            1: return eoc;
            2: return eoc - 28'd1;
            3: return m;
            4: return 28'($urandom) & m;
            default: return 28'($urandom_range(2, max_cluster(kind)));
        endcase
    endfunction

    function automatic dir_row_t row_load(input logic [13:0] idx, input logic [7:0] val);
        dir_row_t r;
        r = '{default: '0};
        r.req = REQ_LOAD;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic dir_row_t row_look(input logic [27:0] cl);
        dir_row_t r;
        r = '{default: '0};
        r.req = REQ_LOOKUP;
        r.cl = cl;
        return r;
    endfunction

    function automatic dir_row_t row_look_typed(input logic [27:0] cl, input chain_res_t res);
        dir_row_t r;
        r = row_look(cl);
        r.typed = 1'b1;
        r.res = res;
        return r;
    endfunction

    function automatic dir_row_t row_reg(input logic [CFG_IDX_W-1:0] ri, input logic [31:0] d);
        dir_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.reg_idx = ri;
        r.reg_data = d;
        return r;
    endfunction

    task automatic send_beat(input logic req, input logic [13:0] idx, input logic [7:0] val,
                             input logic [27:0] cl, input bit typed = 1'b0,
                             input chain_res_t res = '0);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady_sender) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= S_TDATA_W'({cl, val, idx});
        note_typed <= typed;
        note_res   <= res;
        if (req == REQ_LOAD) written[idx] = 1'b1;
        n_sent++;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_lookup(input logic [27:0] cl);
        send_beat(REQ_LOOKUP, 14'($urandom), 8'($urandom), cl);
    endtask

    task automatic send_load(input logic [13:0] idx, input logic [7:0] val);
        send_beat(REQ_LOAD, idx, val, 28'($urandom));
    endtask

    // hold the input side until every result is out and the pipe is empty
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [31:0] d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ri;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_entry(input logic [27:0] cl, input logic [1:0] kind,
                              input logic [27:0] e);
        longint unsigned pos;
        int len;
        logic [7:0] b [4];
        logic [3:0] junk;
        junk = 4'($urandom);
        entry_span(cl, kind, pos, len);
        case (kind)
            KIND_FAT12: begin
                if (cl[0]) begin
                    b[0] = {e[3:0], junk};
                    b[1] = e[11:4];
                end else begin
                    b[0] = e[7:0];
                    b[1] = {junk, e[11:8]};
                end
            end
            KIND_FAT16: begin
                b[0] = e[7:0];
                b[1] = e[15:8];
            end
            default: begin
                b[0] = e[7:0];
                b[1] = e[15:8];
                b[2] = e[23:16];
                b[3] = {junk, e[27:24]};
            end
        endcase
        for (int i = 0; i < len; i++) begin
            send_load(14'(int'(pos) + i), b[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            n_err++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    // model update on configuration writes and accepted beats, and result check
    chain_res_t want_res;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CLUSTER_COUNT:     cfg_count = i_cfg_data[27:0];
                    CFG_DATA_START_SECTOR: cfg_start = i_cfg_data;
                    CFG_CLUSTER_SECTORS:   cfg_secs = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                if (i_s_tuser == REQ_LOAD) begin
                    fat_image[i_s_tdata[13:0]] = i_s_tdata[21:14];
                    n_loads++;
                end else begin
                    pending_q.push_back(note_typed ? note_res : predict_lookup(i_s_tdata[49:22]));
                    n_lookups++;
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                if (pending_q.size() == 0) begin
                    n_err++;
                    $display("%0t: unexpected result beat, actual %h kind %h",
                             $time, o_m_tdata, o_m_tuser);
                end else begin
                    want_res = pending_q.pop_front();
                    n_checked++;
                    check_field("next_entry", 32'(want_res.next_entry), 32'(o_m_tdata[27:0]));
                    check_field("first_sector", want_res.first_sector, o_m_tdata[59:28]);
                    check_field("chain_end", 32'(want_res.chain_end), 32'(o_m_tdata[60]));
                    check_field("fat_kind", 32'(want_res.fat_kind), 32'(o_m_tuser));
                    check_field("outside_table", 32'(want_res.outside_table),
                                32'(o_m_tdata[61]));
                end
            end
        end
    end

    // output side stall patterns
    int rx_mode = 0;
    int rx_left = 0;
    int rx_tick = 0;
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom % 4;
            rx_left <= $urandom_range(64, 512);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= ($urandom % 4) != 0;
            2: i_m_tready <= (rx_tick % 7) < 4;
            default: i_m_tready <= ($urandom % 16) == 0;
        endcase
    end

    dir_row_t dir_rows [$];

    initial begin
        logic [1:0]  kind;
        logic [27:0] count;
        logic [31:0] start;
        logic [7:0]  secs;
        logic [27:0] cl;
        logic [27:0] e;
        int          phase_end;
        int          mid;
        int          pick;
        bit          paused;
        bit          found;

        // reset configuration, FAT12
        dir_rows.push_back(row_look_typed(28'hFFFFFFF,
                           chain_res_t'{28'h0, 32'h0FFFFFFD, 1'b1, KIND_FAT12, 1'b1}));
        dir_rows.push_back(row_load(14'd0, 8'hF8));
        dir_rows.push_back(row_load(14'd1, 8'hFF));
        dir_rows.push_back(row_load(14'd2, 8'hFF));
        dir_rows.push_back(row_look_typed(28'd0,
                           chain_res_t'{28'hFF8, 32'h0, 1'b1, KIND_FAT12, 1'b0}));
        dir_rows.push_back(row_look(28'd1));
        dir_rows.push_back(row_load(14'd3, 8'h03));
        dir_rows.push_back(row_load(14'd4, 8'h40));
        dir_rows.push_back(row_load(14'd5, 8'h00));
        dir_rows.push_back(row_look(28'd2));
        dir_rows.push_back(row_look(28'd3));
        dir_rows.push_back(row_load(14'd16381, 8'hA5));
        dir_rows.push_back(row_load(14'd16382, 8'h5A));
        dir_rows.push_back(row_load(14'h3FFF, 8'hFF));
        dir_rows.push_back(row_look(28'd10921));
        dir_rows.push_back(row_look(28'd10922));
        // lowest FAT16 count, wrapping sector sum
        dir_rows.push_back(row_reg(CFG_CLUSTER_COUNT, 32'd4085));
        dir_rows.push_back(row_reg(CFG_DATA_START_SECTOR, 32'hFFFFFFFF));
        dir_rows.push_back(row_reg(CFG_CLUSTER_SECTORS, 32'd128));
        dir_rows.push_back(row_look(28'd2));
        dir_rows.push_back(row_look(28'd8191));
        dir_rows.push_back(row_look(28'd8192));
        dir_rows.push_back(row_reg(CFG_CLUSTER_COUNT, 32'd65524));
        dir_rows.push_back(row_look(28'd1));
        // lowest FAT32 count, zero sectors per cluster
        dir_rows.push_back(row_reg(CFG_CLUSTER_COUNT, 32'd65525));
        dir_rows.push_back(row_reg(CFG_CLUSTER_SECTORS, 32'd0));
        dir_rows.push_back(row_load(14'd16380, 8'h00));
        dir_rows.push_back(row_look(28'd0));
        dir_rows.push_back(row_look(28'd4095));
        dir_rows.push_back(row_look(28'd4096));
        // masked count, unused index, sectors above range
        dir_rows.push_back(row_reg(CFG_CLUSTER_COUNT, 32'hFFFFFFFF));
        dir_rows.push_back(row_reg(CFG_IDX_UNUSED, 32'h12345678));
        dir_rows.push_back(row_reg(CFG_CLUSTER_SECTORS, 32'd255));
        dir_rows.push_back(row_look(28'hFFFFFFF));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
            end else begin
                send_beat(dir_rows[i].req, dir_rows[i].idx, dir_rows[i].val,
                          dir_rows[i].cl, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            pick = $urandom % 3;
            case (ph % 3)
                0: count = (pick == 0) ? 28'd0 : (pick == 1) ? 28'd4084 :
                           28'($urandom_range(1, 4084));
                1: count = (pick == 0) ? 28'd4085 : (pick == 1) ? 28'd65524 :
                           28'($urandom_range(4085, 65524));
                default: count = (pick == 0) ? 28'd65525 : (pick == 1) ? 28'hFFFFFFF :
                                 28'($urandom_range(65525, 28'hFFFFFFF));
            endcase
            kind = fat_kind_of(count);
            pick = $urandom % 3;
            start = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFFFFFF : $urandom;
            pick = $urandom % 6;
            secs = (pick == 0) ? 8'd1 : (pick == 1) ? 8'd128 : (pick == 4) ? 8'd0 :
                   (pick == 5) ? 8'($urandom_range(129, 255)) : 8'($urandom_range(1, 128));
            write_reg(CFG_CLUSTER_SECTORS, {24'($urandom), secs});
            write_reg(CFG_CLUSTER_COUNT, {(($urandom % 2) != 0) ? 4'($urandom) : 4'h0, count});
            write_reg(CFG_DATA_START_SECTOR, start);
            steady_sender = ($urandom % 4) == 0;
            burst_left = 0;
            phase_end = n_sent + PHASE_BEATS;
            mid = n_sent + PHASE_BEATS / 2;
            paused = 1'b0;
            while (n_sent < phase_end) begin
                if (!paused && n_sent >= mid) begin
                    drain();
                    paused = 1'b1;
                end
                pick = $urandom % 100;
                if (pick < 45) begin
                    // write one entry, look it up, then sometimes follow it
                    cl = (($urandom % 10) == 0) ?
                         28'(max_cluster(kind) - int'($urandom % 4)) :
                         28'($urandom_range(0, max_cluster(kind)));
                    e = pick_entry(kind);
                    load_entry(cl, kind, e);
                    send_lookup(cl);
                    if ((($urandom % 2) != 0) && lookup_safe(e, kind)) send_lookup(e);
                end else if (pick < 65) begin
                    found = 1'b0;
                    for (int t = 0; t < 8 && !found; t++) begin
                        cl = 28'($urandom_range(0, max_cluster(kind)));
                        found = lookup_safe(cl, kind);
                    end
                    if (found) send_lookup(cl);
                end else if (pick < 80) begin
                    cl = (($urandom % 2) != 0) ? 28'($urandom) :
                         28'(max_cluster(kind) + 1 + int'($urandom % 3));
                    if (!lookup_safe(cl, kind)) cl = cl | 28'h8000000;
                    send_lookup(cl);
                end else begin
                    send_load(14'($urandom), 8'($urandom));
                end
            end
        end

        drain();
        if (pending_q.size() != 0) begin
            n_err++;
            $display("%0t: %0d expected results never arrived", $time, pending_q.size());
        end
        $display("covered %0d table loads and %0d lookups, %0d results checked",
                 n_loads, n_lookups, n_checked);
        $display("directed extremes plus %0d random FAT12/16/32 phases", N_PHASES);
        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
